>>> rtl/color_expansion_blitter_assert.svh
// Assertion macros for the color expansion blitter RTL.
`ifndef COLOR_EXPANSION_BLITTER_ASSERT_SVH
`define COLOR_EXPANSION_BLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CEBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CEBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cebl_pkg.sv
// Package: shared types and register indexes of the color expansion blitter.
`timescale 1ns / 1ps
`default_nettype none

package cebl_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BYTES_PER_PIXEL = 3'd0,
        REG_LINE_PITCH      = 3'd1,
        REG_START_OFFSET    = 3'd2,
        REG_RECT_WIDTH      = 3'd3,
        REG_RECT_HEIGHT     = 3'd4,
        REG_FG_COLOR        = 3'd5,
        REG_BG_COLOR        = 3'd6,
        REG_OPAQUE_MODE     = 3'd7
    } t_reg_index;

    localparam int BPP_BITS   = 3;
    localparam int PITCH_BITS = 14;
    localparam int OFFS_BITS  = 24;
    localparam int DIM_BITS   = 13;
    localparam int COLOR_BITS = 32;

    // Static walk settings handed to the address generator
    typedef struct packed {
        logic [BPP_BITS-1:0]   bpp;     // effective bytes per pixel, 1..4
        logic [PITCH_BITS-1:0] pitch;
        logic [OFFS_BITS-1:0]  start;
    } t_walk_cfg;

    // Per-pixel position flags from the address generator
    typedef struct packed {
        logic row_end;
        logic last;
    } t_walk_flags;

endpackage

`default_nettype wire

>>> rtl/cebl_addr_gen.sv
// Address generator: walks the rectangle and tracks the running byte address.
`timescale 1ns / 1ps
`default_nettype none

module cebl_addr_gen #(
    parameter int ADDR_BITS = 24,
    parameter int CW        = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_restart,
    input  wire logic                  i_step,
    input  wire cebl_pkg::t_walk_cfg   i_cfg,
    input  wire logic [CW-1:0]         i_width_m1,
    input  wire logic [CW-1:0]         i_height_m1,
    output logic [ADDR_BITS-1:0]       o_pixel_addr,
    output cebl_pkg::t_walk_flags      o_flags
);

    logic [CW-1:0]        r_col;
    logic [CW-1:0]        r_row;
    logic [ADDR_BITS-1:0] r_row_start;
    logic [ADDR_BITS-1:0] r_pixel;
    logic [CW-1:0]        n_col;
    logic [CW-1:0]        n_row;
    logic [ADDR_BITS-1:0] n_row_start;
    logic [ADDR_BITS-1:0] n_pixel;
    logic [ADDR_BITS-1:0] w_start;
    logic [ADDR_BITS-1:0] w_next_row;

    assign w_start            = ADDR_BITS'(i_cfg.start);
    assign w_next_row         = r_row_start + ADDR_BITS'(i_cfg.pitch);
    assign o_flags.row_end    = (r_col == i_width_m1);
    assign o_flags.last       = o_flags.row_end && (r_row == i_height_m1);
    assign o_pixel_addr       = r_pixel;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_row_start = r_row_start;
        n_pixel     = r_pixel;
        if (i_restart || (i_step && o_flags.last)) begin
            n_col       = '0;
            n_row       = '0;
            n_row_start = w_start;
            n_pixel     = w_start;
        end else if (i_step && o_flags.row_end) begin
            n_col       = '0;
            n_row       = r_row + CW'(1);
            n_row_start = w_next_row;
            n_pixel     = w_next_row;
        end else if (i_step) begin
            n_col   = r_col + CW'(1);
            n_pixel = r_pixel + ADDR_BITS'(i_cfg.bpp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_start <= '0;
            r_pixel     <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_start <= n_row_start;
            r_pixel     <= n_pixel;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cebl_color_fmt.sv
// Color formatter: places the pixel's color bytes in memory order.
`timescale 1ns / 1ps
`default_nettype none

module cebl_color_fmt #(
    parameter int BIG_ENDIAN_MEM = 0
) (
    input  wire logic [cebl_pkg::COLOR_BITS-1:0] i_color,
    input  wire logic [cebl_pkg::BPP_BITS-1:0]   i_bpp,
    input  wire logic                            i_we,
    output logic [cebl_pkg::COLOR_BITS-1:0]      o_bytes
);

    always_comb begin
        logic [1:0] src;
        src     = '0;
        o_bytes = '0;
        for (int k = 0; k < 4; k++) begin
            if (i_we && (3'(k) < i_bpp)) begin
                // big endian: byte k takes color byte (count-1-k)
                src = (BIG_ENDIAN_MEM != 0) ? 2'(i_bpp - 3'd1 - 3'(k)) : 2'(k);
                o_bytes[8*k +: 8] = i_color[8*src +: 8];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/color_expansion_blitter.sv
// Top level: monochrome color expansion blitter with config port and two-stage pipe.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_ready  | i_mask_bit
//  out     | source    | o_out_valid / i_out_ready| o_byte_address, o_write_bytes,
//          |           |                          | o_byte_count, o_write_enable, o_last_pixel
//  cfg     | sink      | i_cfg_we (no wait)       | i_cfg_index, i_cfg_wdata
//
// One mask bit per cycle sustained while the output accepts; a result passes the input
// register, then the result register, before it leaves on the out channel.
// Address generation is one add per pixel (bytes per pixel, or line pitch at row end).
// Reset is synchronous, active low; the walk starts at offset zero after reset.
// Any register write restarts the walk at the start offset, the new one if it is written.
// A stalled output holds its result; with both registers full in_ready drops, so at
// most two transfers are held. The input register takes a transfer while the result
// register drains.
`timescale 1ns / 1ps
`default_nettype none

module color_expansion_blitter #(
    parameter int ADDR_BITS      = 24,
    parameter int MAX_DIM        = 4096,
    parameter int BIG_ENDIAN_MEM = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    // mask bit input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mask_bit,
    // pixel write output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [23:0]      o_byte_address,
    output logic [31:0]      o_write_bytes,
    output logic [2:0]       o_byte_count,
    output logic             o_write_enable,
    output logic             o_last_pixel
);

    `include "color_expansion_blitter_assert.svh"

    // counter width and width used for dimension clamping
    localparam int CW     = $clog2(MAX_DIM);
    localparam int DW     = (cebl_pkg::DIM_BITS > CW + 1) ? cebl_pkg::DIM_BITS : CW + 1;
    localparam int AW_EXT = (ADDR_BITS > 24) ? ADDR_BITS : 24;

    // ---------------- configuration registers ----------------
    logic [cebl_pkg::BPP_BITS-1:0]   r_bpp;
    logic [cebl_pkg::PITCH_BITS-1:0] r_pitch;
    logic [cebl_pkg::OFFS_BITS-1:0]  r_start;
    logic [cebl_pkg::DIM_BITS-1:0]   r_rect_width;
    logic [cebl_pkg::DIM_BITS-1:0]   r_rect_height;
    logic [cebl_pkg::COLOR_BITS-1:0] r_fg;
    logic [cebl_pkg::COLOR_BITS-1:0] r_bg;
    logic                            r_opaque;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp         <= 3'd1;
            r_pitch       <= '0;
            r_start       <= '0;
            r_rect_width  <= 13'd1;
            r_rect_height <= 13'd1;
            r_fg          <= '0;
            r_bg          <= '0;
            r_opaque      <= 1'b0;
        end else if (i_cfg_we) begin
            case (cebl_pkg::t_reg_index'(i_cfg_index))
                cebl_pkg::REG_BYTES_PER_PIXEL: r_bpp         <= i_cfg_wdata[2:0];
                cebl_pkg::REG_LINE_PITCH:      r_pitch       <= i_cfg_wdata[13:0];
                cebl_pkg::REG_START_OFFSET:    r_start       <= i_cfg_wdata[23:0];
                cebl_pkg::REG_RECT_WIDTH:      r_rect_width  <= i_cfg_wdata[12:0];
                cebl_pkg::REG_RECT_HEIGHT:     r_rect_height <= i_cfg_wdata[12:0];
                cebl_pkg::REG_FG_COLOR:        r_fg          <= i_cfg_wdata;
                cebl_pkg::REG_BG_COLOR:        r_bg          <= i_cfg_wdata;
                cebl_pkg::REG_OPAQUE_MODE:     r_opaque      <= i_cfg_wdata[0];
                default:                       r_opaque      <= r_opaque;
            endcase
        end
    end

    // ---------------- effective settings ----------------
    // dimension minus one, with zero acting as one and oversize as MAX_DIM
    function automatic logic [CW-1:0] dim_m1(input logic [cebl_pkg::DIM_BITS-1:0] raw);
        logic [DW-1:0] ext;
        logic [CW-1:0] res;
        ext = DW'(raw);
        if (ext == '0) begin
            res = '0;
        end else if (ext > DW'(MAX_DIM)) begin
            res = CW'(MAX_DIM - 1);
        end else begin
            res = CW'(ext - DW'(1));
        end
        return res;
    endfunction

    logic [cebl_pkg::BPP_BITS-1:0]  w_bpp_eff;
    logic [CW-1:0]                  w_width_m1;
    logic [CW-1:0]                  w_height_m1;
    logic [cebl_pkg::OFFS_BITS-1:0] w_start_next;
    cebl_pkg::t_walk_cfg            w_walk_cfg;

    always_comb begin
        case (r_bpp)
            3'd0:                      w_bpp_eff = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4:    w_bpp_eff = r_bpp;
            default:                   w_bpp_eff = 3'd4;
        endcase
    end

    // a restart caused by a start offset write must already use the new offset
    assign w_start_next = (i_cfg_we &&
                           (cebl_pkg::t_reg_index'(i_cfg_index) == cebl_pkg::REG_START_OFFSET))
                          ? i_cfg_wdata[23:0] : r_start;

    assign w_width_m1       = dim_m1(r_rect_width);
    assign w_height_m1      = dim_m1(r_rect_height);
    assign w_walk_cfg.bpp   = w_bpp_eff;
    assign w_walk_cfg.pitch = r_pitch;
    assign w_walk_cfg.start = w_start_next;

    // ---------------- pipeline control ----------------
    logic r_s1_valid;
    logic r_s1_mask;
    logic w_s1_adv;

    // stage 1 moves on when the result register is empty or draining
    assign w_s1_adv   = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_mask <= i_mask_bit;
        end
    end

    // ---------------- walk and color ----------------
    logic [ADDR_BITS-1:0]  w_pixel_addr;
    cebl_pkg::t_walk_flags w_flags;
    logic                  w_we;
    logic [31:0]           w_color;
    logic [31:0]           w_bytes;
    logic [AW_EXT-1:0]     w_addr_ext;

    cebl_addr_gen #(
        .ADDR_BITS (ADDR_BITS),
        .CW        (CW)
    ) u_addr_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (i_cfg_we),
        .i_step       (w_s1_adv),
        .i_cfg        (w_walk_cfg),
        .i_width_m1   (w_width_m1),
        .i_height_m1  (w_height_m1),
        .o_pixel_addr (w_pixel_addr),
        .o_flags      (w_flags)
    );

    assign w_we       = r_s1_mask || r_opaque;
    assign w_color    = r_s1_mask ? r_fg : r_bg;
    assign w_addr_ext = AW_EXT'(w_pixel_addr);

    cebl_color_fmt #(
        .BIG_ENDIAN_MEM (BIG_ENDIAN_MEM)
    ) u_color_fmt (
        .i_color (w_color),
        .i_bpp   (w_bpp_eff),
        .i_we    (w_we),
        .o_bytes (w_bytes)
    );

    // ---------------- result register ----------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            o_byte_address <= w_addr_ext[23:0];
            o_write_bytes  <= w_bytes;
            o_byte_count   <= w_bpp_eff;
            o_write_enable <= w_we;
            o_last_pixel   <= w_flags.last;
        end
    end

    assign o_out_valid = r_out_valid;

    // ---------------- assertions ----------------
    `CEBL_ASSERT_NOW(a_skip_no_bytes, o_out_valid && !o_write_enable,
        o_write_bytes == 32'd0, "skipped pixel carries color bytes")
    `CEBL_ASSERT_NOW(a_count_range, o_out_valid,
        (o_byte_count != 3'd0) && (o_byte_count <= 3'd4), "byte count out of range")
    `CEBL_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready,
        "input stalled with empty result register")
    `CEBL_ASSERT_NEXT(a_wrap_to_start, w_s1_adv && w_flags.last && !i_cfg_we,
        w_pixel_addr == ADDR_BITS'(r_start), "walk did not return to start after last pixel")

endmodule

`default_nettype wire
